### sv/gpi_pkg.sv
// Shared widths, codes and control structs of the gradient palette interpolator.
// No dependencies; imported by the interfaces and every module of the block.
package gpi_pkg;

  localparam int unsigned CNT_W             = 5;
  localparam int unsigned RANGE_W           = 16;
  localparam int unsigned COLOR_W           = 32;
  localparam int unsigned IDX_W             = 4;
  localparam int unsigned POS_W             = 16;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned NUM_CHAN          = 4;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam int unsigned PALETTE_DEPTH_DEF = 16;
  localparam int unsigned PROD_W            = RANGE_W + CNT_W;

  localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(2);
  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(255);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_COUNT = 1'b0,
    REG_RANGE_MAX   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } idx_side_t;

  typedef struct packed {
    logic               zero;
    logic [COLOR_W-1:0] base;
  } blend_ctl_t;

endpackage

### sv/gpi_if.sv
// Request, result and configuration channels of the gradient palette interpolator.
// Depends on gpi_pkg for field widths.
interface gpi_in_if import gpi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] entry_color;
  logic [POS_W-1:0]   position;

  modport source (output valid, cmd, entry_index, entry_color, position, input ready);
  modport sink   (input valid, cmd, entry_index, entry_color, position, output ready);
endinterface

interface gpi_out_if import gpi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;

  modport source (output valid, color, input ready);
  modport sink   (input valid, color, output ready);
endinterface

interface gpi_cfg_if import gpi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/gpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
// Dividend must satisfy dvd >> QW < den. Depends on gpi_pkg.
module gpi_div import gpi_pkg::*; #(
  parameter int unsigned QW = 8,
  parameter int unsigned DW = RANGE_W,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [DW+QW-1:0] dvd_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             vld_o,
  output logic [QW-1:0]    quo_o,
  output logic [DW-1:0]    rem_o,
  output logic [SW-1:0]    side_o
);

  logic [DW+QW-1:0] acc_q  [QW];
  logic [DW+QW-1:0] acc_d  [QW];
  logic [SW-1:0]    side_q [QW];
  logic [QW-1:0]    vld_q;

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [DW+QW-1:0] a;
    logic [DW:0]      t;
    logic [DW:0]      s;
    logic             ge;

    if (i == 0) begin : g_first
      assign a = dvd_i;
    end else begin : g_next
      assign a = acc_q[i-1];
    end

    assign t  = a[DW+QW-1:QW-1];
    assign ge = (t >= {1'b0, den_i});
    assign s  = ge ? (t - {1'b0, den_i}) : t;
    assign acc_d[i] = {s[DW-1:0], a[QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= (i == 0) ? vld_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i]  <= acc_d[i];
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = acc_q[QW-1][QW-1:0];
  assign rem_o  = acc_q[QW-1][DW+QW-1:QW];
  assign side_o = side_q[QW-1];

endmodule

### sv/gpi_pal.sv
// Palette memory: one write port, two registered read ports, held while stalled.
// Depends on gpi_pkg for the word width.
module gpi_pal import gpi_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int unsigned AW            = $clog2(PALETTE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [COLOR_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr0_i,
  input  logic [AW-1:0]      raddr1_i,
  output logic [COLOR_W-1:0] rdata0_o,
  output logic [COLOR_W-1:0] rdata1_o
);

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

### sv/gpi_blend.sv
// Per-channel blend: |diff|*frac, four divider lanes by range_max, sign restore.
// Depends on gpi_pkg and gpi_div.
module gpi_blend import gpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [RANGE_W-1:0] frac_i,
  input  logic [RANGE_W-1:0] den_i,
  input  logic [COLOR_W-1:0] base_i,
  input  logic [COLOR_W-1:0] nxt_i,
  output logic               vld_o,
  output logic [COLOR_W-1:0] color_o
);

  localparam int unsigned LW = CHAN_W + RANGE_W;
  localparam int unsigned SW = 1 + CHAN_W + $bits(blend_ctl_t);

  logic                  p_vld_q;
  logic [LW-1:0]         p_prod_q [NUM_CHAN];
  logic [LW-1:0]         p_prod_d [NUM_CHAN];
  logic [NUM_CHAN-1:0]   p_neg_q;
  logic [NUM_CHAN-1:0]   p_neg_d;
  blend_ctl_t            p_ctl_q;
  logic [NUM_CHAN-1:0]   l_vld;
  logic [CHAN_W-1:0]     l_quo [NUM_CHAN];
  logic [RANGE_W-1:0]    l_rem [NUM_CHAN];
  logic [SW-1:0]         l_side [NUM_CHAN];
  blend_ctl_t            o_ctl;
  logic [COLOR_W-1:0]    mix;

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_ln
    localparam int unsigned SH = COLOR_W - CHAN_W * (k + 1);
    logic [CHAN_W:0]   diff;
    logic [CHAN_W-1:0] mag;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] q;

    assign diff = {1'b0, nxt_i[SH +: CHAN_W]} - {1'b0, base_i[SH +: CHAN_W]};
    assign p_neg_d[k] = diff[CHAN_W];
    assign mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    assign p_prod_d[k] = LW'(mag) * LW'(frac_i);

    gpi_div #(.QW(CHAN_W), .DW(RANGE_W), .SW(SW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (p_vld_q),
      .dvd_i  (p_prod_q[k]),
      .den_i  (den_i),
      .side_i ({p_neg_q[k], p_ctl_q.base[SH +: CHAN_W], p_ctl_q}),
      .vld_o  (l_vld[k]),
      .quo_o  (l_quo[k]),
      .rem_o  (l_rem[k]),
      .side_o (l_side[k])
    );

    assign lo = l_side[k][SW-2 -: CHAN_W];
    assign q  = l_quo[k];
    assign mix[SH +: CHAN_W] = l_side[k][SW-1] ? (lo - q) : (lo + q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_prod_q     <= p_prod_d;
      p_neg_q      <= p_neg_d;
      p_ctl_q.zero <= (frac_i == '0);
      p_ctl_q.base <= base_i;
    end
  end

  assign o_ctl   = blend_ctl_t'(l_side[0][$bits(blend_ctl_t)-1:0]);
  assign vld_o   = l_vld[0];
  assign color_o = o_ctl.zero ? o_ctl.base : mix;

endmodule

### sv/gradient_palette_interpolator.sv
// Gradient palette interpolator: takes one request per clock (palette write or
// position lookup) and returns one RGBA colour for each lookup, in order. The rate
// of one per cycle is set by the two single-write-port palette memory reads per
// lookup and by the fully pipelined dividers (five quotient stages for the entry
// index, eight for each channel blend). The pipeline only stalls when a result is
// waiting at the output.
module gradient_palette_interpolator import gpi_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  gpi_in_if.sink    in_i,
  gpi_out_if.source out_o,
  gpi_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned EW = AW + CNT_W;
  localparam int unsigned WW = AW + IDX_W;

  logic [CNT_W-1:0]   cc_q;
  logic [RANGE_W-1:0] rm_q;
  logic [RANGE_W-1:0] den;
  logic [15:0]        cnt_w;
  logic [15:0]        cnt_eff;
  logic [CNT_W-1:0]   cm1;
  logic [POS_W-1:0]   pos;

  logic               en;
  logic               accept;
  logic               a_vld_q;
  idx_side_t          a_side_q;
  logic [PROD_W-1:0]  a_prod_q;

  logic               dv_vld;
  logic [CNT_W-1:0]   dv_q;
  logic [RANGE_W-1:0] dv_r;
  idx_side_t          dv_side;
  logic [EW-1:0]      elem_ext;
  logic [EW-1:0]      nx_ext;
  logic [WW-1:0]      wr_ext;
  logic               we;

  logic               m_vld_q;
  logic [RANGE_W-1:0] m_frac_q;
  logic [COLOR_W-1:0] rd0;
  logic [COLOR_W-1:0] rd1;

  logic               t_vld;
  logic [COLOR_W-1:0] t_color;
  logic               out_vld_q;
  logic [COLOR_W-1:0] out_col_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= COUNT_RST;
      rm_q <= RANGE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_COLOR_COUNT: cc_q <= cfg_i.data[CNT_W-1:0];
        REG_RANGE_MAX:   rm_q <= cfg_i.data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign den     = (rm_q == '0) ? RANGE_W'(1) : rm_q;
  assign cnt_w   = 16'(cc_q);
  assign cnt_eff = (cnt_w == '0) ? 16'd1 :
                   (cnt_w > 16'(PALETTE_DEPTH)) ? 16'(PALETTE_DEPTH) : cnt_w;
  assign cm1     = CNT_W'(cnt_eff - 16'd1);
  assign pos     = (in_i.position > den) ? den : in_i.position;

  // stall only when a result must wait behind a held one
  assign en       = !out_vld_q || out_o.ready || !t_vld;
  assign in_i.ready = en;
  assign accept   = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q.cmd   <= cmd_e'(in_i.cmd);
      a_side_q.idx   <= in_i.entry_index;
      a_side_q.color <= in_i.entry_color;
      a_prod_q       <= PROD_W'(pos) * PROD_W'(cm1);
    end
  end

  gpi_div #(.QW(CNT_W), .DW(RANGE_W), .SW($bits(idx_side_t))) u_idx_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (a_vld_q),
    .dvd_i  (a_prod_q),
    .den_i  (den),
    .side_i (a_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_q),
    .rem_o  (dv_r),
    .side_o (dv_side)
  );

  // palette access: writes travel the same pipe so they stay ordered with lookups
  assign elem_ext = {{AW{1'b0}}, dv_q};
  assign nx_ext   = elem_ext + EW'(1);
  assign wr_ext   = {{AW{1'b0}}, dv_side.idx};
  assign we       = dv_vld && (dv_side.cmd == CMD_WRITE) && (wr_ext < WW'(PALETTE_DEPTH));

  gpi_pal #(.PALETTE_DEPTH(PALETTE_DEPTH), .AW(AW)) u_pal (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (we),
    .waddr_i  (wr_ext[AW-1:0]),
    .wdata_i  (dv_side.color),
    .raddr0_i (elem_ext[AW-1:0]),
    .raddr1_i (nx_ext[AW-1:0]),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= dv_vld && (dv_side.cmd == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_frac_q <= dv_r;
    end
  end

  gpi_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (m_vld_q),
    .frac_i  (m_frac_q),
    .den_i   (den),
    .base_i  (rd0),
    .nxt_i   (rd1),
    .vld_o   (t_vld),
    .color_o (t_color)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && t_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && t_vld) begin
      out_col_q <= t_color;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.color = out_col_q;

  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_vld && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("pipeline advanced over a held result");

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && (dv_side.cmd == CMD_LOOKUP)) |-> (elem_ext < EW'(PALETTE_DEPTH)))
    else $error("palette entry index beyond depth");

  a_next_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && (dv_side.cmd == CMD_LOOKUP) && (dv_r != '0)) |->
    (nx_ext < EW'(PALETTE_DEPTH)))
    else $error("neighbour entry index beyond depth");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(t_vld))
    else $error("result raised without a lookup at the tail");

endmodule
